// ===== rtl/gid_pkg.sv =====
package gid_pkg;

   localparam int MAX_ROWS = 4096;
   localparam int MAX_COLS = 4096;
   localparam int LANES = 8;
   localparam int NIBBLE_W = 4;
   localparam logic [3:0] NIBBLE_MASK = 4'hf;
   localparam int NIBBLES_PER_WORD = 32 / 4;
   localparam int CFG_W = 13;
   localparam int ROW_W = 12;
   localparam int COL_W = 12;
   localparam int GRP_W = 9;
   localparam int OCT_W = 9;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CSR_COLS = 2'd0;
   localparam logic [1:0] CSR_ROWS = 2'd1;
   localparam logic [1:0] CSR_GROUP = 2'd2;

   localparam logic [31:0] QNAN = 32'h7fc00000;
   localparam logic [31:0] INF_BITS = 32'h7f800000;

   typedef struct packed {
      logic [31:0] weight_word;
      logic [3:0] zero_nib;
      logic [31:0] scale_bits;
      logic [ROW_W-1:0] row_base;
      logic [COL_W-1:0] column_index;
      logic [GRP_W-1:0] group_index;
      logic last_item;
   } work_type;

   typedef struct packed {
      logic [LANES-1:0][31:0] value;
      logic [ROW_W-1:0] row_base;
      logic [COL_W-1:0] column_index;
      logic [GRP_W-1:0] group_index;
      logic last_item;
   } result_type;

   // clamp a row-type register to 8..MAX_ROWS, multiple of eight
   function automatic logic [CFG_W-1:0] eff_rows(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      begin
         r = v;
         if (r < CFG_W'(8)) r = CFG_W'(8);
         if (r > CFG_W'(MAX_ROWS)) r = CFG_W'(MAX_ROWS);
         return {r[CFG_W-1:3], 3'b000};
      end
   endfunction

   // special-case result of diff * scale; valid=0 means normal path
   function automatic logic [32:0] mul_special(input logic signed [4:0] diff,
                                               input logic [31:0] s);
      logic [7:0] e;
      logic [22:0] f;
      logic sg;
      begin
         e = s[30:23];
         f = s[22:0];
         sg = s[31] ^ diff[4];
         if (e == 8'hff && f != 0) return {1'b1, s | 32'h00400000};
         if (diff == 0) return {1'b1, (e == 8'hff) ? QNAN : {s[31], 31'd0}};
         if (e == 8'hff) return {1'b1, sg, INF_BITS[30:0]};
         if (e == 0 && f == 0) return {1'b1, sg, 31'd0};
         return 33'd0;
      end
   endfunction

   // finite nonzero: mag (1..15) times scale, round to nearest even
   function automatic logic [31:0] mul_finite(input logic [3:0] mag,
                                              input logic [31:0] s, input logic sg);
      logic [23:0] m;
      logic [27:0] prod;
      logic [4:0] msb;
      logic signed [10:0] e2;
      logic signed [10:0] be;
      logic signed [10:0] sh;
      logic [27:0] mant;
      logic [27:0] rem;
      logic [27:0] half;
      logic [31:0] bits;
      begin
         if (s[30:23] == 0) begin
            m = {1'b0, s[22:0]};
            e2 = -11'sd149;
         end else begin
            m = {1'b1, s[22:0]};
            e2 = 11'(s[30:23]) - 11'sd150;
         end
         prod = m * mag;
         msb = 0;
         for (int i = 1; i < 28; i++) if (prod[i]) msb = 5'(i);
         be = 11'(msb) + e2 + 11'sd127;
         sh = (be >= 1) ? (11'(msb) - 11'sd23) : (-11'sd149 - e2);
         if (sh <= 0) begin
            mant = prod << (-sh);
            rem = 0;
            half = 1;
         end else begin
            mant = prod >> sh;
            rem = prod & ((28'd1 << sh) - 28'd1);
            half = 28'd1 << (sh - 1);
            if (rem > half || (rem == half && mant[0])) mant = mant + 28'd1;
         end
         if (be >= 1) begin
            if (be > 255) return {sg, INF_BITS[30:0]};
            bits = {be[7:0] - 8'd1, 23'd0} + 32'(mant);
         end else begin
            bits = 32'(mant);
         end
         if (bits >= INF_BITS) bits = INF_BITS;
         return {sg, bits[30:0]};
      end
   endfunction

endpackage

// ===== rtl/gid_stream_if.sv =====
interface gid_stream_if #(parameter int W = 32);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/gid_front.sv =====
// Sequencer: tracks octet, column and group, picks the zero nibble.
module gid_front import gid_pkg::*; (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [CFG_W-1:0] csr_wdata,
   input logic in_valid,
   output logic in_ready,
   input logic [31:0] weight_word,
   input logic [31:0] zero_word,
   input logic [31:0] scale_bits,
   output logic q_valid,
   input logic q_ready,
   output work_type q_data
);
   logic [CFG_W-1:0] cols_ff, rows_ff, grp_ff;
   logic [OCT_W-1:0] oct_ff;
   logic [COL_W-1:0] col_ff;
   logic [GRP_W-1:0] gcnt_ff;
   logic [ROW_W-1:0] rig_ff;
   logic [CFG_W-1:0] cols_eff, rows_eff, grp_eff;
   logic last;
   logic [COL_W:0] col_in;
   logic [ROW_W-1:0] rig_in;
   logic take;
   logic [2:0] lane;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= CFG_W'(4096);
         rows_ff <= CFG_W'(4096);
         grp_ff <= CFG_W'(128);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLS: cols_ff <= csr_wdata;
            CSR_ROWS: rows_ff <= csr_wdata;
            CSR_GROUP: grp_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cols_eff = cols_ff;
      if (cols_eff < CFG_W'(1)) cols_eff = CFG_W'(1);
      if (cols_eff > CFG_W'(MAX_COLS)) cols_eff = CFG_W'(MAX_COLS);
      rows_eff = eff_rows(rows_ff);
      grp_eff = eff_rows(grp_ff);
      last = ({1'b0, col_ff} + 13'd1 >= cols_eff) &&
             ({1'b0, oct_ff, 3'b000} + 13'd8 >= rows_eff);
      col_in = {1'b0, col_ff} + 13'd1;
      rig_in = rig_ff + ROW_W'(8);
      lane = col_ff[2:0];
   end

   assign in_ready = q_ready;
   assign q_valid = in_valid;
   assign take = in_valid && q_ready;

   always_comb begin
      q_data.weight_word = weight_word;
      q_data.zero_nib = 4'((zero_word >> {lane, 2'b00}) & 32'(NIBBLE_MASK));
      q_data.scale_bits = scale_bits;
      q_data.row_base = {oct_ff, 3'b000};
      q_data.column_index = col_ff;
      q_data.group_index = gcnt_ff;
      q_data.last_item = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff <= '0;
         col_ff <= '0;
         gcnt_ff <= '0;
         rig_ff <= '0;
      end else if (take) begin
         if (last) begin
            oct_ff <= '0;
            col_ff <= '0;
            gcnt_ff <= '0;
            rig_ff <= '0;
         end else if (col_in >= cols_eff) begin
            col_ff <= '0;
            oct_ff <= oct_ff + OCT_W'(1);
            if ({1'b0, rig_in} >= grp_eff || rig_in == 0) begin
               rig_ff <= '0;
               gcnt_ff <= gcnt_ff + GRP_W'(1);
            end else begin
               rig_ff <= rig_in;
            end
         end else begin
            col_ff <= col_in[COL_W-1:0];
         end
      end
   end
endmodule

// ===== rtl/gid_queue.sv =====
// Two-entry FIFO between sequencer and multiplier lanes.
module gid_queue import gid_pkg::*; (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input work_type in_data,
   output logic out_valid,
   input logic out_ready,
   output work_type out_data
);
   work_type mem_ff [QUEUE_DEPTH];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== rtl/gid_back.sv =====
// Eight float lanes: subtract, multiply, round; registered output.
module gid_back import gid_pkg::*; (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input work_type in_data,
   output logic out_valid,
   input logic out_ready,
   output result_type out_data
);
   result_type res_in;
   result_type res_ff;
   logic valid_ff;
   logic signed [4:0] diff [LANES];
   logic [32:0] spec [LANES];
   logic [3:0] mag [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         diff[i] = $signed({1'b0, in_data.weight_word[i*NIBBLE_W +: NIBBLE_W]}) -
                   $signed({1'b0, in_data.zero_nib});
         mag[i] = diff[i][4] ? 4'(-diff[i]) : diff[i][3:0];
         spec[i] = mul_special(diff[i], in_data.scale_bits);
         res_in.value[i] = spec[i][32] ? spec[i][31:0] :
            mul_finite(mag[i], in_data.scale_bits, in_data.scale_bits[31] ^ diff[i][4]);
      end
      res_in.row_base = in_data.row_base;
      res_in.column_index = in_data.column_index;
      res_in.group_index = in_data.group_index;
      res_in.last_item = in_data.last_item;
   end

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = res_ff;

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (in_ready) valid_ff <= in_valid;
   end
endmodule

// ===== rtl/grouped_int4_weight_dequant_top.sv =====
// Grouped 4-bit weight dequantizer.
// req channel: one beat = packed weight word, zero-point word, fp32 scale.
// rsp channel: one beat = eight fp32 values (weight - zero) * scale, RNE,
//   plus row base, column, group index and a last flag.
// csr port: write-only; index 0 columns, 1 rows, 2 group rows.
//   Write only while the block is idle.
// Path: an accepted req beat goes into a queue entry, then into the result
//   reg, where rsp_valid rises and the rsp beat can be taken.
// Throughput: one beat per cycle unless rsp stalls, set by eight mul lanes.
// Reset (synchronous): counters to zero, registers to 4096/4096/128,
//   queue and output register empty.
// Backpressure: when rsp stalls the result register holds and the
//   two-entry queue absorbs beats; req_ready drops once it is full.
// After the beat flagged last, counters restart for a new matrix.
module grouped_int4_weight_dequant_top import gid_pkg::*; (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [CFG_W-1:0] csr_wdata,
   input logic req_valid,
   output logic req_ready,
   input logic [31:0] req_weight_word,
   input logic [31:0] req_zero_word,
   input logic [31:0] req_scale_bits,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [31:0] rsp_value0,
   output logic [31:0] rsp_value1,
   output logic [31:0] rsp_value2,
   output logic [31:0] rsp_value3,
   output logic [31:0] rsp_value4,
   output logic [31:0] rsp_value5,
   output logic [31:0] rsp_value6,
   output logic [31:0] rsp_value7,
   output logic [ROW_W-1:0] rsp_row_base,
   output logic [COL_W-1:0] rsp_column_index,
   output logic [GRP_W-1:0] rsp_group_index,
   output logic rsp_last_item
);
   gid_stream_if #(.W($bits(work_type))) fq ();
   gid_stream_if #(.W($bits(work_type))) qb ();
   result_type res;

   gid_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .in_valid(req_valid), .in_ready(req_ready),
      .weight_word(req_weight_word), .zero_word(req_zero_word),
      .scale_bits(req_scale_bits),
      .q_valid(fq.valid), .q_ready(fq.ready), .q_data(fq.data)
   );

   gid_queue u_queue (
      .clock, .reset,
      .in_valid(fq.valid), .in_ready(fq.ready), .in_data(fq.data),
      .out_valid(qb.valid), .out_ready(qb.ready), .out_data(qb.data)
   );

   gid_back u_back (
      .clock, .reset,
      .in_valid(qb.valid), .in_ready(qb.ready), .in_data(qb.data),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(res)
   );

   assign rsp_value0 = res.value[0];
   assign rsp_value1 = res.value[1];
   assign rsp_value2 = res.value[2];
   assign rsp_value3 = res.value[3];
   assign rsp_value4 = res.value[4];
   assign rsp_value5 = res.value[5];
   assign rsp_value6 = res.value[6];
   assign rsp_value7 = res.value[7];
   assign rsp_row_base = res.row_base;
   assign rsp_column_index = res.column_index;
   assign rsp_group_index = res.group_index;
   assign rsp_last_item = res.last_item;
endmodule

// ===== rtl/gid_checker.sv =====
module gid_checker import gid_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [31:0] rsp_value0,
   input logic [ROW_W-1:0] rsp_row_base
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value0))
      else $error("rsp beat dropped under stall");
   a_rowalign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_base[2:0] == 3'b000)
      else $error("row base not octet aligned");
   a_idle_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");
   a_noin: assert property (@(posedge clock) disable iff (reset)
      $past(reset) == 1'b0 && !$past(req_valid) && !$past(rsp_valid) && !rsp_valid
      |=> !rsp_valid || $past(req_valid))
      else $error("rsp beat without req");
endmodule

bind grouped_int4_weight_dequant_top gid_checker u_checker (
   .clock, .reset, .req_valid, .rsp_valid, .rsp_ready,
   .rsp_value0, .rsp_row_base
);
